// ===== rtl/sbpl_pkg.sv =====
// ---------------------------------------------------------------------------
// Set-bit position lister package
// Shared widths, register indexes and sequencer states of the lister.
// ---------------------------------------------------------------------------
`default_nettype none

package sbpl_pkg;

   localparam int unsigned LenWidth   = 30;
   localparam int unsigned OffWidth   = 31;
   localparam int unsigned LimWidth   = 34;
   localparam int unsigned PosWidth   = 32;
   localparam int unsigned CntWidth   = 33;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDatWidth = 34;
   localparam int unsigned RngWidth   = 32;

   // Longest string that the range arithmetic honours.
   localparam logic [LenWidth-1:0] MaxStringBytes = 30'd536870912;

   localparam logic [CsrIdxWidth-1:0] CsrStringLength  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrStartOffset   = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrEndOffset     = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrPositionLimit = 3'd3;

   localparam logic KindPosition = 1'b0;
   localparam logic KindEnd      = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RANGE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/set_bit_position_lister.sv =====
// ---------------------------------------------------------------------------
// Set-bit position lister
// Lists the absolute positions of the set bits of a string in a byte range.
// ---------------------------------------------------------------------------
// Bytes arrive on the req_ channel one per transfer, in index order; the
// item with req_final_byte set closes the string. Each set bit inside the
// configured byte range gives one position result on the rsp_ channel,
// numbered most significant bit first, until the position limit is used
// up. The closing item adds an end result that carries the total count,
// and rsp_run_last marks the last result of each input item.
// An item is taken in while the sequencer is idle, the range state
// resolves the byte range, then a shift register presents one bit per
// cycle to the emit logic in the scan state while no result waits, and
// the finish state gives the end result. req_ready is high only while
// the sequencer is idle. A single output register holds each result;
// while the receiver holds rsp_ready low the scan waits on the bit that
// has a result to deliver. Registers are to be written on the csr_
// channel while the block is idle, which the block does not check.
// Reset restores the register defaults and clears the byte count.
// ---------------------------------------------------------------------------
`default_nettype none

module set_bit_position_lister (
   input  wire logic                                  clock,
   input  wire logic                                  reset,

   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [7:0]                            req_data_byte,
   input  wire logic                                  req_byte_present,
   input  wire logic                                  req_final_byte,

   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_result_kind,
   output logic [sbpl_pkg::PosWidth-1:0]              rsp_bit_position,
   output logic [sbpl_pkg::CntWidth-1:0]              rsp_total_count,
   output logic                                       rsp_run_last,

   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [sbpl_pkg::CsrIdxWidth-1:0]      csr_index,
   input  wire logic [sbpl_pkg::CsrDatWidth-1:0]      csr_data
);

   // Configuration registers
   logic [sbpl_pkg::LenWidth-1:0]        str_len_ff;
   logic signed [sbpl_pkg::OffWidth-1:0] start_off_ff;
   logic signed [sbpl_pkg::OffWidth-1:0] end_off_ff;
   logic signed [sbpl_pkg::LimWidth-1:0] limit_ff;

   // Per-string state
   logic [sbpl_pkg::LenWidth-1:0]        byte_idx_ff, byte_idx_in;
   logic [sbpl_pkg::CntWidth-1:0]        emitted_ff, emitted_in;
   logic signed [sbpl_pkg::LimWidth-1:0] remain_ff, remain_in;

   // Sequencer
   sbpl_pkg::state_type                  state_ff, state_in;
   logic [7:0]                           byte_sh_ff, byte_sh_in;
   logic [2:0]                           bit_off_ff, bit_off_in;
   logic                                 final_ff, final_in;
   logic signed [sbpl_pkg::RngWidth-1:0] start_eff_ff, start_eff_in;
   logic signed [sbpl_pkg::RngWidth-1:0] end_eff_ff, end_eff_in;

   // Output register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_kind_ff, rsp_kind_in;
   logic [sbpl_pkg::PosWidth-1:0]        rsp_pos_ff, rsp_pos_in;
   logic [sbpl_pkg::CntWidth-1:0]        rsp_cnt_ff, rsp_cnt_in;
   logic                                 rsp_last_ff, rsp_last_in;

   logic                                 req_fire;
   logic                                 csr_fire;
   logic                                 out_free;
   logic                                 in_range;
   logic                                 emit_bit;
   logic                                 scan_step;

   logic [sbpl_pkg::LenWidth-1:0]        len_cl;
   logic signed [sbpl_pkg::RngWidth-1:0] len_s;
   logic signed [sbpl_pkg::RngWidth-1:0] start_s, end_s;
   logic signed [sbpl_pkg::RngWidth-1:0] start_add, end_add;
   logic signed [sbpl_pkg::RngWidth-1:0] end_low;
   logic signed [sbpl_pkg::RngWidth-1:0] idx_s;

   assign req_ready = (state_ff == sbpl_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid & req_ready;
   assign csr_fire  = csr_valid & csr_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_bit_position = rsp_pos_ff;
   assign rsp_total_count  = rsp_cnt_ff;
   assign rsp_run_last     = rsp_last_ff;

   // Range resolution, registered in the range state.
   always_comb begin
      len_cl    = (str_len_ff > sbpl_pkg::MaxStringBytes) ? sbpl_pkg::MaxStringBytes
                                                          : str_len_ff;
      len_s     = signed'({2'b00, len_cl});
      start_s   = signed'({start_off_ff[sbpl_pkg::OffWidth-1], start_off_ff});
      end_s     = signed'({end_off_ff[sbpl_pkg::OffWidth-1], end_off_ff});
      start_add = (start_s < 0) ? (start_s + len_s) : start_s;
      end_add   = (end_s < 0) ? (end_s + len_s) : end_s;
      end_low   = (end_add < 0) ? '0 : end_add;
      start_eff_in = (start_add < 0) ? '0 : start_add;
      end_eff_in   = (end_low >= len_s) ? (len_s - 1) : end_low;
   end

   assign idx_s     = signed'({2'b00, byte_idx_ff});
   assign in_range  = (start_eff_ff <= end_eff_ff) && (idx_s >= start_eff_ff)
                      && (idx_s <= end_eff_ff);
   assign emit_bit  = in_range && (remain_ff != '0) && byte_sh_ff[7];
   assign scan_step = ~emit_bit | out_free;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sbpl_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_byte_present) begin
                  state_in = sbpl_pkg::ST_RANGE;
               end else if (req_final_byte) begin
                  state_in = sbpl_pkg::ST_FINISH;
               end
            end
         end
         sbpl_pkg::ST_RANGE: begin
            state_in = sbpl_pkg::ST_SCAN;
         end
         sbpl_pkg::ST_SCAN: begin
            if (scan_step && (bit_off_ff == 3'd7)) begin
               state_in = final_ff ? sbpl_pkg::ST_FINISH : sbpl_pkg::ST_IDLE;
            end
         end
         sbpl_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = sbpl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sbpl_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and output register
   always_comb begin
      byte_sh_in   = byte_sh_ff;
      bit_off_in   = bit_off_ff;
      final_in     = final_ff;
      byte_idx_in  = byte_idx_ff;
      emitted_in   = emitted_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         sbpl_pkg::ST_IDLE: begin
            if (req_fire) begin
               byte_sh_in = req_data_byte;
               bit_off_in = '0;
               final_in   = req_final_byte;
            end
         end
         sbpl_pkg::ST_SCAN: begin
            if (scan_step) begin
               byte_sh_in = {byte_sh_ff[6:0], 1'b0};
               bit_off_in = bit_off_ff + 3'd1;
               if (bit_off_ff == 3'd7) begin
                  byte_idx_in = byte_idx_ff + 1'b1;
               end
            end
            if (emit_bit && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = sbpl_pkg::KindPosition;
               rsp_pos_in   = {byte_idx_ff[sbpl_pkg::PosWidth-4:0], bit_off_ff};
               rsp_cnt_in   = '0;
               // Last when no later bit can still be emitted for this item.
               rsp_last_in  = ~final_ff && ((byte_sh_ff[6:0] == 7'd0) ||
                              (remain_ff == {{(sbpl_pkg::LimWidth-1){1'b0}}, 1'b1}));
               if (emitted_ff != {sbpl_pkg::CntWidth{1'b1}}) begin
                  emitted_in = emitted_ff + 1'b1;
               end
               if (remain_ff > 0) begin
                  remain_in = remain_ff - 1'b1;
               end
            end
         end
         sbpl_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = sbpl_pkg::KindEnd;
               rsp_pos_in   = '0;
               rsp_cnt_in   = emitted_ff;
               rsp_last_in  = 1'b1;
               byte_idx_in  = '0;
               emitted_in   = '0;
               remain_in    = limit_ff;
            end
         end
         default: begin
         end
      endcase
      // A limit write also reloads the running allowance.
      if (csr_fire && (csr_index == sbpl_pkg::CsrPositionLimit)) begin
         remain_in = signed'(csr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbpl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         byte_idx_ff  <= '0;
         emitted_ff   <= '0;
         remain_ff    <= '1;
         str_len_ff   <= '0;
         start_off_ff <= '0;
         end_off_ff   <= '1;
         limit_ff     <= '1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         byte_idx_ff  <= byte_idx_in;
         emitted_ff   <= emitted_in;
         remain_ff    <= remain_in;
         if (csr_fire) begin
            case (csr_index)
               sbpl_pkg::CsrStringLength: begin
                  str_len_ff <= csr_data[sbpl_pkg::LenWidth-1:0];
               end
               sbpl_pkg::CsrStartOffset: begin
                  start_off_ff <= signed'(csr_data[sbpl_pkg::OffWidth-1:0]);
               end
               sbpl_pkg::CsrEndOffset: begin
                  end_off_ff <= signed'(csr_data[sbpl_pkg::OffWidth-1:0]);
               end
               sbpl_pkg::CsrPositionLimit: begin
                  limit_ff <= signed'(csr_data);
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_sh_ff   <= byte_sh_in;
      bit_off_ff   <= bit_off_in;
      final_ff     <= final_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_last_ff  <= rsp_last_in;
      if (state_ff == sbpl_pkg::ST_RANGE) begin
         start_eff_ff <= start_eff_in;
         end_eff_ff   <= end_eff_in;
      end
   end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Set-bit position lister testbench
// Drives byte strings and register settings into the lister, predicts every
// position and end result in a scoreboard, and checks them in order while
// both sides idle and stall at random.
// ---------------------------------------------------------------------------

module tb_top;

   localparam int DrainCycles = 16;
   localparam int StallLimit  = 3000;
   localparam int RandomItems = 240;
   localparam int HoldCycles  = 300;

   typedef struct packed {
      logic                          kind;
      logic [sbpl_pkg::PosWidth-1:0] pos;
      logic [sbpl_pkg::CntWidth-1:0] count;
      logic                          run_last;
   } result_type;

   class lister_scoreboard_type;
      logic [sbpl_pkg::LenWidth-1:0] str_len;
      longint                        start_off;
      longint                        end_off;
      longint                        pos_limit;
      longint                        remaining;
      logic [sbpl_pkg::LenWidth-1:0] byte_idx;
      logic [sbpl_pkg::CntWidth-1:0] emitted;
      result_type                    pending_q[$];
      int                            failures;

      function new();
         str_len   = '0;
         start_off = 0;
         end_off   = -1;
         pos_limit = -1;
         remaining = -1;
         byte_idx  = '0;
         emitted   = '0;
         failures  = 0;
      endfunction

      function void note_config(logic [sbpl_pkg::CsrIdxWidth-1:0] idx,
                                logic [sbpl_pkg::CsrDatWidth-1:0] data);
         case (idx)
            sbpl_pkg::CsrStringLength: str_len = data[sbpl_pkg::LenWidth-1:0];
            sbpl_pkg::CsrStartOffset:  start_off = {{33{data[30]}}, data[30:0]};
            sbpl_pkg::CsrEndOffset:    end_off = {{33{data[30]}}, data[30:0]};
            sbpl_pkg::CsrPositionLimit: begin
               pos_limit = {{30{data[33]}}, data[33:0]};
               remaining = pos_limit;
            end
            default: ;
         endcase
      endfunction

      // Works out every result that one accepted transfer gives.
      function void note_input(logic [7:0] data, logic present, logic closing);
         result_type fresh[$];
         result_type r;
         longint     len, lo, hi, idx;
         if (present) begin
            len = str_len;
            if (len > longint'(sbpl_pkg::MaxStringBytes)) len = sbpl_pkg::MaxStringBytes;
            lo  = start_off;
            hi  = end_off;
            idx = byte_idx;
            if (lo < 0) lo += len;
            if (hi < 0) hi += len;
            if (lo < 0) lo = 0;
            if (hi < 0) hi = 0;
            if (hi >= len) hi = len - 1;
            if (lo <= hi && idx >= lo && idx <= hi) begin
               for (int off = 0; off < 8 && remaining != 0; off++) begin
                  if (data[7-off]) begin
                     r      = '0;
                     r.kind = sbpl_pkg::KindPosition;
                     r.pos  = 32'(idx * 8 + off);
                     fresh.push_back(r);
                     if (emitted != '1) emitted++;
                     if (remaining > 0) remaining--;
                  end
               end
            end
            byte_idx = byte_idx + 1'b1;
         end
         if (closing) begin
            r       = '0;
            r.kind  = sbpl_pkg::KindEnd;
            r.count = emitted;
            fresh.push_back(r);
            byte_idx  = '0;
            emitted   = '0;
            remaining = pos_limit;
         end
         if (fresh.size() > 0) fresh[fresh.size()-1].run_last = 1'b1;
         foreach (fresh[i]) pending_q.push_back(fresh[i]);
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: kind %0d pos %0d count %0d last %0d",
                        got.kind, got.pos, got.count, got.run_last);
            return;
         end
         want = pending_q.pop_front();
         if (got.kind !== want.kind || got.pos !== want.pos ||
             got.count !== want.count || got.run_last !== want.run_last) begin
            failures++;
            if (failures <= 10)
               $display({"mismatch: expected kind %0d pos %0d count %0d last %0d, ",
                         "got kind %0d pos %0d count %0d last %0d"},
                        want.kind, want.pos, want.count, want.run_last,
                        got.kind, got.pos, got.count, got.run_last);
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic [7:0]                       req_data_byte;
   logic                             req_byte_present;
   logic                             req_final_byte;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic                             rsp_result_kind;
   logic [sbpl_pkg::PosWidth-1:0]    rsp_bit_position;
   logic [sbpl_pkg::CntWidth-1:0]    rsp_total_count;
   logic                             rsp_run_last;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [sbpl_pkg::CsrIdxWidth-1:0] csr_index;
   logic [sbpl_pkg::CsrDatWidth-1:0] csr_data;

   lister_scoreboard_type board = new();
   int  items_sent   = 0;
   int  inputs_taken = 0;
   int  gap_pct      = 0;
   bit  quiet        = 0;
   bit  stall_mode   = 1;

   set_bit_position_lister u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_final_byte   (req_final_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_bit_position (rsp_bit_position),
      .rsp_total_count  (rsp_total_count),
      .rsp_run_last     (rsp_run_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.note_config(csr_index, csr_data);
         if (req_valid && req_ready) begin
            board.note_input(req_data_byte, req_byte_present, req_final_byte);
            inputs_taken++;
         end
         if (rsp_valid && rsp_ready)
            board.check_result({rsp_result_kind, rsp_bit_position, rsp_total_count,
                                rsp_run_last});
      end
   end

   // Result side: random stall bursts, with one long hold-off so that the block
   // fills up and refuses further transfers.
   initial begin : result_sink
      bit held;
      held      = 0;
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 63) == 0) stall_mode = !stall_mode;
         if (!held && inputs_taken >= 60) begin
            held = 1;
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
            rsp_ready <= 1'b1;
         end else if (!quiet && stall_mode && $urandom_range(0, 99) < 15) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= StallLimit) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [sbpl_pkg::CsrIdxWidth-1:0] idx,
                            logic [sbpl_pkg::CsrDatWidth-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_item(logic [7:0] data, logic present, logic closing);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= data;
      req_byte_present <= present;
      req_final_byte   <= closing;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // A fill below zero gives random bytes; a bare end marker may close the string.
   task automatic send_string(int count, int fill, bit bare_end);
      logic [7:0] b;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 11) == 0) send_item(8'($urandom), 1'b0, 1'b0);
         b = (fill < 0) ? 8'($urandom) : 8'(fill);
         send_item(b, 1'b1, (i == count - 1) && !bare_end);
         items_sent++;
      end
      if (count == 0 || bare_end) begin
         send_item(8'($urandom), 1'b0, 1'b1);
         items_sent++;
      end
   endtask

   // Registers may only change once every result is out and the block has
   // finished any transfer that gives no result.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic longint rand_offset();
      case ($urandom_range(0, 19))
         0, 1:    return {{33{1'b0}}, 31'($urandom)} - (longint'(1) << 30);
         2:       return -(longint'(1) << 30);
         3:       return (longint'(1) << 30) - 1;
         default: return longint'($urandom_range(0, 24)) - 12;
      endcase
   endfunction

   function automatic longint rand_limit();
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4: return -1;
         5, 6:          return longint'({$urandom, $urandom} & 64'h3_FFFF_FFFF) -
                               (longint'(1) << 33);
         7:             return (longint'(1) << 33) - 1;
         8:             return -(longint'(1) << 33);
         default:       return $urandom_range(0, 12);
      endcase
   endfunction

   function automatic logic [sbpl_pkg::LenWidth-1:0] rand_length(int base);
      int n;
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return 30'($urandom);
         2:       return sbpl_pkg::MaxStringBytes;
         3:       return '1;
         default: begin
            n = base + $urandom_range(0, 4) - 2;
            return (n < 0) ? '0 : 30'(n);
         end
      endcase
   endfunction

   initial begin : stimulus
      int base;
      int fill;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      req_byte_present = 1'b0;
      req_final_byte   = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Default registers give an empty string length, so only the end result.
      send_item(8'hA5, 1'b1, 1'b1);
      wait_idle();
      csr_write(sbpl_pkg::CsrStringLength, 34'd4);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h01, 1'b1, 1'b1);
      // A bare marker without the final flag is ignored; with it, an empty string.
      send_item(8'h3C, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      wait_idle();
      csr_write(sbpl_pkg::CsrPositionLimit, 34'd0);
      send_string(2, 255, 0);
      wait_idle();
      // The limit is reloaded at the end of each string.
      csr_write(sbpl_pkg::CsrPositionLimit, 34'd3);
      send_string(2, 255, 0);
      send_string(1, 255, 1);
      wait_idle();
      csr_write(sbpl_pkg::CsrStringLength, 34'd6);
      csr_write(sbpl_pkg::CsrStartOffset, 34'(-2));
      csr_write(sbpl_pkg::CsrEndOffset, 34'(-1));
      csr_write(sbpl_pkg::CsrPositionLimit, 34'(-1));
      send_string(6, 255, 0);
      wait_idle();
      csr_write(sbpl_pkg::CsrStringLength, 34'h3FFF_FFFF);
      csr_write(sbpl_pkg::CsrStartOffset, 34'(-(longint'(1) << 30)));
      csr_write(sbpl_pkg::CsrEndOffset, 34'((longint'(1) << 30) - 1));
      csr_write(sbpl_pkg::CsrPositionLimit, 34'((longint'(1) << 33) - 1));
      send_string(3, -1, 0);
      wait_idle();
      // Start beyond end gives an empty range; an unused index is ignored.
      csr_write(sbpl_pkg::CsrStartOffset, 34'd3);
      csr_write(sbpl_pkg::CsrEndOffset, 34'd1);
      csr_write(sbpl_pkg::CsrPositionLimit, 34'(-(longint'(1) << 33)));
      csr_write(3'(sbpl_pkg::CsrPositionLimit + 4), '1);
      send_string(2, -1, 0);
      wait_idle();
      // Bytes past the string length fall outside the range.
      csr_write(sbpl_pkg::CsrStringLength, 34'd2);
      csr_write(sbpl_pkg::CsrStartOffset, 34'd0);
      csr_write(sbpl_pkg::CsrEndOffset, 34'd5);
      send_string(4, 255, 0);

      items_sent = 0;
      while (items_sent < RandomItems) begin
         wait_idle();
         quiet   = items_sent > RandomItems - 40;
         gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
         base    = ($urandom_range(0, 9) == 0) ? 30 : $urandom_range(0, 10);
         fill    = ($urandom_range(0, 7) == 0) ? 255 : -1;
         if ($urandom_range(0, 9) < 7)
            csr_write(sbpl_pkg::CsrStringLength, 34'(rand_length(base)));
         if ($urandom_range(0, 9) < 7)
            csr_write(sbpl_pkg::CsrStartOffset, 34'(rand_offset()));
         if ($urandom_range(0, 9) < 7)
            csr_write(sbpl_pkg::CsrEndOffset, 34'(rand_offset()));
         if ($urandom_range(0, 9) < 7)
            csr_write(sbpl_pkg::CsrPositionLimit, 34'(rand_limit()));
         if ($urandom_range(0, 19) == 0)
            csr_write(3'(sbpl_pkg::CsrPositionLimit + $urandom_range(1, 4)),
                      34'({$urandom, $urandom}));
         repeat ($urandom_range(1, 4)) begin
            send_string(($urandom_range(0, 3) == 0) ? $urandom_range(0, base + 3) : base,
                        fill, $urandom_range(0, 7) == 0);
         end
      end

      wait_idle();
      if (board.pending_q.size() != 0)
         $display("%0d expected results never arrived", board.pending_q.size());
      if (board.failures == 0 && board.pending_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sbpl_pkg.sv
rtl/set_bit_position_lister.sv
verif/tb_top.sv
